@@ sv/spnp_pkg.sv @@
// Package for the spectrum peak-normalising plot block.
// Holds field widths, mode and register codes, command and state types.
// No dependencies.
`default_nettype none

package spnp_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned HGT_W  = 10;
  localparam int unsigned PIX_W  = 11;
  localparam int unsigned PROD_W = VAL_W + CFG_W;
  // Quotient bits kept by the divider; anything larger saturates anyway.
  localparam int unsigned QUO_W  = HGT_W + 1;
  localparam int unsigned CNT_W  = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Mode codes of an input item.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [1:0] CFG_X_ORIGIN   = 2'd1;
  localparam logic [1:0] CFG_Y_ORIGIN   = 2'd2;

  localparam logic [CFG_W-1:0] FULL_SCALE_RST = 10'd400;
  localparam logic [CFG_W-1:0] X_ORIGIN_RST   = 10'd20;
  localparam logic [CFG_W-1:0] Y_ORIGIN_RST   = 10'd20;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_FRAME
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] full_scale;
    logic [CFG_W-1:0] x_origin;
    logic [CFG_W-1:0] y_origin;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_DIVSTART,
    B_DIVWAIT,
    B_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

`default_nettype wire

@@ sv/spnp_front.sv @@
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on spnp_pkg.
`default_nettype none

module spnp_front #(
  parameter int unsigned NUM_BINS = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                mode_i,
  input  wire logic [spnp_pkg::IDX_W-1:0] bin_index_i,
  input  wire logic [spnp_pkg::VAL_W-1:0] bin_value_i,
  output logic                           q_valid_o,
  output spnp_pkg::cmd_t                 q_cmd_o,
  input  wire logic                      q_pop_i
);
  import spnp_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  logic accept;
  logic in_range;
  logic keep;
  logic push;
  logic pop;
  cmd_t cmd;

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(bin_index_i) < NUM_BINS);

  always_comb begin
    cmd.idx      = bin_index_i;
    cmd.value    = bin_value_i;
    cmd.in_range = in_range;
    cmd.kind     = CMD_LOAD;
    keep         = 1'b0;
    case (mode_i)
      MODE_LOAD: begin
        cmd.kind = CMD_LOAD;
        // An out-of-range load has no effect at all, so it is dropped here.
        keep     = in_range;
      end
      MODE_READ: begin
        cmd.kind = CMD_READ;
        keep     = 1'b1;
      end
      MODE_FRAME: begin
        cmd.kind = CMD_FRAME;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push      = accept && keep;
  assign pop       = q_pop_i && q_valid_o;
  assign q_valid_o = (count_q != '0);
  assign q_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

@@ sv/spnp_div.sv @@
// Radix-2 restoring divider giving min(dividend / divisor, limit), 0 for a zero divisor.
// Depends on spnp_pkg.
`default_nettype none

module spnp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [spnp_pkg::PROD_W-1:0] dividend_i,
  input  wire logic [spnp_pkg::VAL_W-1:0]  divisor_i,
  input  wire logic [spnp_pkg::CFG_W-1:0]  limit_i,
  output logic                            done_o,
  output logic [spnp_pkg::HGT_W-1:0]      quo_o
);
  import spnp_pkg::*;

  div_state_e         state_q, state_d;
  logic [PROD_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0]  dsr_q, dsr_d;
  logic [VAL_W-1:0]   dv_q, dv_d;
  logic [CFG_W-1:0]   lim_q, lim_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic              ge;
  logic              over;
  logic [PROD_W:0]   top_bound;

  assign ge        = (rem_q >= dsr_q);
  // The remainder is below divisor * 2^QUO_W once the overflow check has passed.
  assign top_bound = {dv_q, QUO_W'(0)};
  assign over      = ({1'b0, rem_q} >= top_bound);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    dv_d    = dv_q;
    lim_d   = lim_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_o  = 1'b0;
    quo_o   = (quo_q > QUO_W'(lim_q)) ? lim_q : quo_q[HGT_W-1:0];
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_d   = dividend_i;
          dsr_d   = {divisor_i, HGT_W'(0)};
          dv_d    = divisor_i;
          lim_d   = limit_i;
          quo_d   = '0;
          cnt_d   = CNT_W'(QUO_W - 1);
          state_d = DIV_CHECK;
        end
      end
      DIV_CHECK: begin
        if (dv_q == '0) begin
          quo_d   = '0;
          state_d = DIV_DONE;
        end else if (over) begin
          quo_d   = {1'b0, lim_q};
          state_d = DIV_DONE;
        end else begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (ge) begin
          rem_d = rem_q - dsr_q;
        end
        quo_d = {quo_q[QUO_W-2:0], ge};
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        done_o  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dv_q  <= dv_d;
    lim_q <= lim_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

endmodule

`default_nettype wire

@@ sv/spnp_back.sv @@
// Back end: executes queued commands against the bin store and the running peak,
// scales read bins through the divider and holds the result register.
// Depends on spnp_pkg and spnp_div.
`default_nettype none

module spnp_back #(
  parameter int unsigned NUM_BINS = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire spnp_pkg::cfg_t             cfg_i,
  input  wire logic                       q_valid_i,
  input  wire spnp_pkg::cmd_t             q_cmd_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [spnp_pkg::IDX_W-1:0]      out_index_o,
  output logic [spnp_pkg::HGT_W-1:0]      scaled_height_o,
  output logic [spnp_pkg::PIX_W-1:0]      pixel_col_o,
  output logic [spnp_pkg::PIX_W-1:0]      pixel_row_o
);
  import spnp_pkg::*;

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [VAL_W-1:0]   peak_q, peak_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [HGT_W-1:0]   hgt_q, hgt_d;
  logic [VAL_W-1:0]   rdata_q;
  logic [VAL_W-1:0]   mem [NUM_BINS];
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_index_q;
  logic [HGT_W-1:0]   out_hgt_q;
  logic [PIX_W-1:0]   out_col_q;
  logic [PIX_W-1:0]   out_row_q;

  logic               mem_we;
  logic               mem_re;
  logic               div_start;
  logic               div_done;
  logic [HGT_W-1:0]   div_quo;
  logic               out_load;
  logic [AW+IDX_W-1:0] addr_ext;
  logic [AW-1:0]      addr;
  logic [VAL_W-1:0]   fetched;

  // Widen then cut, so the address fits any store depth.
  assign addr_ext = {AW'(0), q_cmd_i.idx};
  assign addr     = addr_ext[AW-1:0];
  assign fetched  = cmd_q.in_range ? rdata_q : '0;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    peak_d    = peak_q;
    prod_d    = prod_q;
    hgt_d     = hgt_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.kind)
            CMD_LOAD: begin
              mem_we = 1'b1;
              if (q_cmd_i.value > peak_q) begin
                peak_d = q_cmd_i.value;
              end
            end
            CMD_FRAME: begin
              peak_d = '0;
            end
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = B_FETCH;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_FETCH: begin
        prod_d  = PROD_W'(fetched) * PROD_W'(cfg_i.full_scale);
        state_d = B_DIVSTART;
      end
      B_DIVSTART: begin
        div_start = 1'b1;
        state_d   = B_DIVWAIT;
      end
      B_DIVWAIT: begin
        if (div_done) begin
          hgt_d   = div_quo;
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  spnp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (peak_q),
    .limit_i    (cfg_i.full_scale),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    hgt_q  <= hgt_d;
    if (out_load) begin
      out_index_q <= cmd_q.idx;
      out_hgt_q   <= hgt_q;
      out_col_q   <= PIX_W'(cfg_i.x_origin) + PIX_W'(cmd_q.idx);
      out_row_q   <= PIX_W'(cfg_i.y_origin) + PIX_W'(cfg_i.full_scale) - PIX_W'(hgt_q);
    end
  end

  // Bin store: one write or one read port per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= q_cmd_i.value;
    end
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_index_o     = out_index_q;
  assign scaled_height_o = out_hgt_q;
  assign pixel_col_o     = out_col_q;
  assign pixel_row_o     = out_row_q;

endmodule

`default_nettype wire

@@ sv/spectrum_peak_normalize_plot.sv @@
// Spectrum peak-normalising plot block: top level with configuration registers.
// Depends on spnp_pkg, spnp_front and spnp_back.
//
// Usage: spectrum bins are loaded with mode load (the running peak follows the
// largest value loaded), a new frame clears the peak, and a read returns the bin
// scaled to bin * full_scale / peak (saturated at full_scale, 0 for a zero peak)
// with its plot column and the top row of its trace mark.
// The input channel takes a transaction when in_valid_i is high and in_stall_o is
// low; a two-entry command queue sits behind it, so items are taken while the
// back end is busy or a result waits. The output channel moves a transaction when
// out_valid_o is high and out_stall_i is low; the result register holds its value
// while stalled, and further reads then wait in the back end and queue.
// Loads and new frames are done by the back end straight from idle. A read occupies
// the back end for the store read, the multiply, the divider start, the radix-2
// divider (overflow check, 11 quotient bits unless a zero peak or an overflow ends
// it early, finish) and the load of the result register; the back end takes no
// new command until a read is through, while the queue takes items until full.
// Reset clears the peak, the queue and the output valid, and loads the register
// defaults (full_scale 400, both origins 20). The bin store is not cleared.
`default_nettype none

module spectrum_peak_normalize_plot #(
  parameter int unsigned NUM_BINS = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [spnp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [spnp_pkg::IDX_W-1:0] bin_index_i,
  input  wire logic [spnp_pkg::VAL_W-1:0] bin_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [spnp_pkg::IDX_W-1:0]      out_index_o,
  output logic [spnp_pkg::HGT_W-1:0]      scaled_height_o,
  output logic [spnp_pkg::PIX_W-1:0]      pixel_col_o,
  output logic [spnp_pkg::PIX_W-1:0]      pixel_row_o
);
  import spnp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FULL_SCALE: cfg_d.full_scale = cfg_wdata_i;
        CFG_X_ORIGIN:   cfg_d.x_origin   = cfg_wdata_i;
        CFG_Y_ORIGIN:   cfg_d.y_origin   = cfg_wdata_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale <= FULL_SCALE_RST;
      cfg_q.x_origin   <= X_ORIGIN_RST;
      cfg_q.y_origin   <= Y_ORIGIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spnp_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .bin_index_i (bin_index_i),
    .bin_value_i (bin_value_i),
    .q_valid_o   (q_valid),
    .q_cmd_o     (q_cmd),
    .q_pop_i     (q_pop)
  );

  spnp_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .scaled_height_o (scaled_height_o),
    .pixel_col_o     (pixel_col_o),
    .pixel_row_o     (pixel_row_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for spectrum_peak_normalize_plot: directed table, then framed
// random traffic over several register settings, with random output stalls and a long hold-off.
// Depends on spnp_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;
  import spnp_pkg::*;

  localparam int NUM_BINS        = 512;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int IDLE_PERCENT    = 36;

  // Mode code that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [HGT_W-1:0] height;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } plot_point_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             known;
    plot_point_t      point;
  } dir_row_t;

  // Rows with known set carry the point read straight off the defaults
  // (full scale 400, both origins 20); the others go through the predictor.
  localparam int NUM_DIRECTED = 24;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{MODE_LOAD,   9'd0,   32'd0,          1'b0, '0},
    '{MODE_READ,   9'd0,   32'd0,          1'b1, '{9'd0,   10'd0,   11'd20,  11'd420}},
    '{MODE_LOAD,   9'd511, 32'hFFFF_FFFF,  1'b0, '0},
    '{MODE_READ,   9'd511, 32'd0,          1'b1, '{9'd511, 10'd400, 11'd531, 11'd20}},
    '{MODE_READ,   9'd0,   32'hFFFF_FFFF,  1'b1, '{9'd0,   10'd0,   11'd20,  11'd420}},
    '{MODE_LOAD,   9'd1,   32'd1,          1'b0, '0},
    '{MODE_READ,   9'd1,   32'd0,          1'b1, '{9'd1,   10'd0,   11'd21,  11'd420}},
    '{MODE_FRAME,  9'd0,   32'd0,          1'b0, '0},
    '{MODE_READ,   9'd511, 32'd0,          1'b1, '{9'd511, 10'd0,   11'd531, 11'd420}},
    '{MODE_LOAD,   9'd2,   32'd100,        1'b0, '0},
    '{MODE_READ,   9'd511, 32'd0,          1'b1, '{9'd511, 10'd400, 11'd531, 11'd20}},
    '{MODE_READ,   9'd2,   32'd0,          1'b1, '{9'd2,   10'd400, 11'd22,  11'd20}},
    '{MODE_LOAD,   9'd3,   32'd50,         1'b0, '0},
    '{MODE_READ,   9'd3,   32'd0,          1'b1, '{9'd3,   10'd200, 11'd23,  11'd220}},
    '{MODE_LOAD,   9'd4,   32'd33,         1'b0, '0},
    '{MODE_READ,   9'd4,   32'd0,          1'b0, '0},
    '{MODE_UNUSED, 9'd511, 32'hFFFF_FFFF,  1'b0, '0},
    '{MODE_READ,   9'd2,   32'd0,          1'b0, '0},
    '{MODE_LOAD,   9'd5,   32'h8000_0000,  1'b0, '0},
    '{MODE_READ,   9'd2,   32'd0,          1'b0, '0},
    '{MODE_READ,   9'd5,   32'd0,          1'b1, '{9'd5,   10'd400, 11'd25,  11'd20}},
    '{MODE_READ,   9'd511, 32'd0,          1'b1, '{9'd511, 10'd400, 11'd531, 11'd20}},
    '{MODE_LOAD,   9'd6,   32'h7FFF_FFFF,  1'b0, '0},
    '{MODE_READ,   9'd6,   32'd0,          1'b0, '0}
  };

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_idx   = CFG_FULL_SCALE;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [1:0]       mode      = MODE_LOAD;
  logic [IDX_W-1:0] bin_index = '0;
  logic [VAL_W-1:0] bin_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic [HGT_W-1:0] scaled_height;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;

  spectrum_peak_normalize_plot #(
    .NUM_BINS(NUM_BINS)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .bin_index_i    (bin_index),
    .bin_value_i    (bin_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_index_o    (out_index),
    .scaled_height_o(scaled_height),
    .pixel_col_o    (pixel_col),
    .pixel_row_o    (pixel_row)
  );

  // Shadow of the block's state.
  logic [VAL_W-1:0] bin_mag [NUM_BINS];
  bit               bin_loaded [NUM_BINS];
  logic [IDX_W-1:0] loaded_bins [$];
  logic [VAL_W-1:0] peak_mag = '0;
  cfg_t             setting  = '{FULL_SCALE_RST, X_ORIGIN_RST, Y_ORIGIN_RST};

  plot_point_t expected_points [$];

  bit gaps_on      = 1'b1;
  int holds_asked  = 0;
  int holds_done   = 0;
  int items_sent   = 0;
  int points_seen  = 0;
  int mismatches   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [HGT_W-1:0] scaled_of(logic [VAL_W-1:0] mag);
    logic [63:0] prod;
    logic [63:0] quo;
    if (peak_mag == '0) return '0;
    prod = 64'(mag) * 64'(setting.full_scale);
    quo  = prod / 64'(peak_mag);
    if (quo > 64'(setting.full_scale)) quo = 64'(setting.full_scale);
    return quo[HGT_W-1:0];
  endfunction

  function automatic plot_point_t predict_plot_point(logic [IDX_W-1:0] idx);
    plot_point_t      p;
    logic [VAL_W-1:0] mag;
    mag      = (int'(idx) < NUM_BINS) ? bin_mag[idx] : '0;
    p.idx    = idx;
    p.height = scaled_of(mag);
    p.col    = {1'b0, setting.x_origin} + {2'b00, idx};
    p.row    = {1'b0, setting.y_origin} + {1'b0, setting.full_scale} - {1'b0, p.height};
    return p;
  endfunction

  // Applies one accepted transaction to the shadow state.
  task automatic account_item(input logic [1:0] m, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] v, input logic known,
                              input plot_point_t known_point);
    case (m)
      MODE_LOAD: begin
        if (int'(idx) < NUM_BINS) begin
          bin_mag[idx] = v;
          if (!bin_loaded[idx]) begin
            bin_loaded[idx] = 1'b1;
            loaded_bins.push_back(idx);
          end
          if (v > peak_mag) peak_mag = v;
        end
      end
      MODE_FRAME: peak_mag = '0;
      MODE_READ: begin
        if (known) expected_points.push_back(known_point);
        else expected_points.push_back(predict_plot_point(idx));
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items never glitch it.
  task automatic send_item(input logic [1:0] m, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] v, input logic known = 1'b0,
                           input plot_point_t known_point = '0);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    bin_index <= idx;
    bin_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_item(m, idx, v, known, known_point);
    if (m != MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // Loads and frames leave no trace at the output; give them time to retire.
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_FULL_SCALE: setting.full_scale = data;
      CFG_X_ORIGIN:   setting.x_origin   = data;
      CFG_Y_ORIGIN:   setting.y_origin   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_magnitude();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1000);
      6:       return 32'd1 << $urandom_range(31);
      7:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] any_loaded_bin();
    return loaded_bins[$urandom_range(loaded_bins.size() - 1)];
  endfunction

  // Mostly a whole frame: clear the peak, load some bins, read them back.
  // Otherwise a single stray transaction.
  task automatic random_burst();
    int               n_loads;
    int               n_reads;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] frame_bins [$];
    if ($urandom_range(99) < 75) begin
      send_item(MODE_FRAME, IDX_W'($urandom_range(NUM_BINS - 1)), $urandom);
      n_loads = $urandom_range(1, 10);
      repeat (n_loads) begin
        idx = IDX_W'($urandom_range(NUM_BINS - 1));
        frame_bins.push_back(idx);
        send_item(MODE_LOAD, idx, rand_magnitude());
      end
      n_reads = $urandom_range(1, n_loads + 4);
      repeat (n_reads) begin
        if ($urandom_range(3) != 0) idx = frame_bins[$urandom_range(frame_bins.size() - 1)];
        else idx = any_loaded_bin();
        send_item(MODE_READ, idx, $urandom);
      end
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_item(MODE_LOAD, IDX_W'($urandom_range(NUM_BINS - 1)),
                              rand_magnitude());
        4, 5, 6, 7: send_item(MODE_READ, any_loaded_bin(), $urandom);
        8:          send_item(MODE_FRAME, IDX_W'($urandom_range(NUM_BINS - 1)), $urandom);
        default:    send_item(MODE_UNUSED, IDX_W'($urandom_range(NUM_BINS - 1)), $urandom);
      endcase
    end
  endtask

  function automatic cfg_t setting_for(int phase);
    cfg_t s;
    case (phase)
      0: s = '{10'd1023, 10'd1023, 10'd1023};
      1: s = '{10'd1,    10'd0,    10'd0};
      2: s = '{10'd1023, 10'd0,    10'd1023};
      3: s = '{10'd1,    10'd1023, 10'd0};
      default: begin
        s.full_scale = CFG_W'($urandom_range(1, 1023));
        s.x_origin   = CFG_W'($urandom_range(1023));
        s.y_origin   = CFG_W'($urandom_range(1023));
      end
    endcase
    return s;
  endfunction

  // Output side: random stalls, plus a long hold-off when asked for one.
  initial begin : output_stall_gen
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  task automatic check_point();
    plot_point_t want;
    if (expected_points.size() == 0) begin
      $error("unexpected result transaction for bin %0d", out_index);
      mismatches++;
      return;
    end
    want = expected_points.pop_front();
    points_seen++;
    if (out_index !== want.idx) begin
      $error("out_index: expected %0d, got %0d", want.idx, out_index);
      mismatches++;
    end
    if (scaled_height !== want.height) begin
      $error("scaled_height: expected %0d, got %0d", want.height, scaled_height);
      mismatches++;
    end
    if (pixel_col !== want.col) begin
      $error("pixel_col: expected %0d, got %0d", want.col, pixel_col);
      mismatches++;
    end
    if (pixel_row !== want.row) begin
      $error("pixel_row: expected %0d, got %0d", want.row, pixel_row);
      mismatches++;
    end
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_point();
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_points.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int   phase;
    int   target;
    bit   paused_mid;
    cfg_t s;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(DIRECTED[r].mode, DIRECTED[r].idx, DIRECTED[r].value,
                DIRECTED[r].known, DIRECTED[r].point);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_outputs();
      s = setting_for(phase);
      write_cfg(CFG_FULL_SCALE, s.full_scale);
      write_cfg(CFG_X_ORIGIN, s.x_origin);
      write_cfg(CFG_Y_ORIGIN, s.y_origin);
      // One phase runs flat out on both sides; another opens with a long
      // output hold-off while the sender keeps pushing.
      gaps_on = (phase != 2);
      if (phase == 3) holds_asked++;
      paused_mid = 1'b0;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if (phase == 5 && !paused_mid && items_sent >= target - ITEMS_PER_PHASE / 2) begin
          drain_outputs();
          paused_mid = 1'b1;
        end
        random_burst();
      end
    end
    drain_outputs();

    $display("Covered %0d transactions across %0d register settings; %0d plot points checked.",
             items_sent, NUM_PHASES + 1, points_seen);
    $display("Included zero peaks, saturated heights, ignored mode, stalls and a long hold-off.");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
